// ===== hdl/qhc_pkg.sv =====
package qhc_pkg;

  localparam int unsigned DefNumThresholds = 6;
  localparam int unsigned DefProfileSlots  = 12;
  localparam int unsigned DefCountWidth    = 32;
  localparam int unsigned MaxThresholds    = 6;
  localparam int unsigned QueueDepth       = 2;

  typedef enum logic [1:0] {
    FuncRecord = 2'd0,
    FuncRead   = 2'd1,
    FuncClear  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    RegRowTotal   = 3'd0,
    RegActiveThr  = 3'd1,
    RegThresholdA = 3'd2
  } reg_e;

  localparam logic [31:0] FixedLimit [4] = '{32'd500, 32'd1000, 32'd5000, 32'd10000};

  typedef struct packed {
    logic [1:0]               func;
    logic [6:0]               addr;
    logic [4:0]               bin;
    logic [1:0]               cls;
    logic                     bad;
    logic                     under;
    logic [MaxThresholds-1:0] hit;
    logic [3:0]               fix;
  } entry_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  bin;
    logic [1:0]  cls;
    logic        bad;
  } result_t;

endpackage

// ===== hdl/qhc_fifo.sv =====
module qhc_fifo import qhc_pkg::*; #(
  parameter type         T     = entry_t,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/qhc_front.sv =====
module qhc_front import qhc_pkg::*; #(
  parameter int unsigned NumThresholds = DefNumThresholds,
  parameter int unsigned ProfileSlots  = DefProfileSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] true_card_i,
  input  logic [31:0] est_card_i,
  input  logic [6:0]  counter_addr_i,
  output logic        ent_valid_o,
  output entry_t      ent_o,
  input  logic        ent_full_i
);

  logic [31:0] row_total_q;
  logic [2:0]  active_q;
  logic [31:0] thr_q [MaxThresholds];
  entry_t      ent_d, ent_q;
  logic        valid_q, adv;

  logic [31:0] a, b, hi, lo, rt;
  logic [2:0]  nact;
  logic        bad;
  logic [4:0]  bin;

  always_comb begin
    a    = (true_card_i == '0) ? 32'd1 : true_card_i;
    b    = (est_card_i == '0) ? 32'd1 : est_card_i;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    bad  = {6'd0, hi} > {5'd0, lo, 1'b0};
    bin  = 5'(ProfileSlots - 3);
    for (int i = ProfileSlots - 4; i >= 1; i--) begin
      if ({6'd0, hi} <= 38'(lo) * 38'(i + 2)) begin
        bin = 5'(i);
      end
    end
    if (!bad) begin
      bin = '0;
    end
    rt   = (row_total_q == '0) ? 32'd1 : row_total_q;
    nact = (active_q > 3'(NumThresholds)) ? 3'(NumThresholds) : active_q;

    ent_d       = '0;
    ent_d.func  = func_i;
    ent_d.addr  = counter_addr_i;
    ent_d.bin   = bin;
    ent_d.bad   = bad;
    ent_d.under = true_card_i > est_card_i;
    if (true_card_i < 32'd2) begin
      ent_d.cls = 2'd0;
    end else if (40'(true_card_i) * 40'd200 <= 40'(rt)) begin
      ent_d.cls = 2'd1;
    end else if (40'(true_card_i) * 40'd50 <= 40'(rt)) begin
      ent_d.cls = 2'd2;
    end else begin
      ent_d.cls = 2'd3;
    end
    for (int t = 0; t < MaxThresholds; t++) begin
      ent_d.hit[t] = (t < NumThresholds) && (3'(t) < nact) &&
                     (true_card_i > thr_q[t] || est_card_i > thr_q[t]);
    end
    for (int k = 0; k < 4; k++) begin
      ent_d.fix[k] = (true_card_i > FixedLimit[k]) && bad;
    end
  end

  assign full_o      = valid_q && ent_full_i;
  assign adv         = !full_o;
  assign ent_valid_o = valid_q;
  assign ent_o       = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_total_q <= '0;
      active_q    <= '0;
      for (int t = 0; t < MaxThresholds; t++) begin
        thr_q[t] <= '0;
      end
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegRowTotal) begin
          row_total_q <= cfg_wdata_i;
        end else if (cfg_idx_i == RegActiveThr) begin
          active_q <= cfg_wdata_i[2:0];
        end else begin
          thr_q[cfg_idx_i - RegThresholdA] <= cfg_wdata_i;
        end
      end
      if (adv) begin
        valid_q <= push_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push_i) begin
      ent_q <= ent_d;
    end
  end

endmodule

// ===== hdl/qhc_back.sv =====
module qhc_back import qhc_pkg::*; #(
  parameter int unsigned NumThresholds = DefNumThresholds,
  parameter int unsigned ProfileSlots  = DefProfileSlots,
  parameter int unsigned CountWidth    = DefCountWidth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    ent_empty_i,
  input  entry_t  ent_i,
  output logic    ent_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam int unsigned ProfN       = NumThresholds * ProfileSlots;
  localparam int unsigned OverallBase = ProfN + NumThresholds * 4;
  localparam int unsigned FixedBase   = OverallBase + 4;
  localparam int unsigned MapEnd      = FixedBase + 4;
  localparam int unsigned IdxW        = $clog2(MapEnd);

  logic [CountWidth-1:0] cnt_q [MapEnd];
  logic [MapEnd-1:0]     inc;
  logic                  fire, rec;
  logic [7:0]            addr_ext;
  logic [CountWidth-1:0] rd;

  assign fire       = !ent_empty_i && !res_full_i;
  assign ent_pop_o  = fire;
  assign res_push_o = fire;
  assign rec        = fire && (ent_i.func == FuncRecord);
  assign addr_ext   = {1'b0, ent_i.addr};

  always_comb begin
    inc = '0;
    if (rec) begin
      for (int t = 0; t < NumThresholds; t++) begin
        for (int s = 0; s < ProfileSlots; s++) begin
          inc[t*ProfileSlots+s] = ent_i.hit[t] &&
            ((ent_i.bin == 5'(s)) ||
             (ent_i.bad && (s == ProfileSlots - 2) && ent_i.under) ||
             (ent_i.bad && (s == ProfileSlots - 1) && !ent_i.under));
        end
        for (int c = 0; c < 4; c++) begin
          inc[ProfN+t*4+c] = ent_i.hit[t] && ent_i.bad && (ent_i.cls == 2'(c));
        end
      end
      for (int c = 0; c < 4; c++) begin
        inc[OverallBase+c] = (ent_i.cls == 2'(c));
        inc[FixedBase+c]   = ent_i.fix[c];
      end
    end
  end

  always_comb begin
    rd    = (addr_ext < 8'(MapEnd)) ? cnt_q[addr_ext[IdxW-1:0]] : '0;
    res_o = '0;
    if (ent_i.func == FuncRead) begin
      res_o.read_data = 32'(rd);
    end else if (ent_i.func == FuncRecord) begin
      res_o.bin = ent_i.bin[3:0];
      res_o.cls = ent_i.cls;
      res_o.bad = ent_i.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MapEnd; j++) begin
        cnt_q[j] <= '0;
      end
    end else if (fire && (ent_i.func == FuncClear)) begin
      for (int j = 0; j < MapEnd; j++) begin
        cnt_q[j] <= '0;
      end
    end else begin
      for (int j = 0; j < MapEnd; j++) begin
        if (inc[j] && (cnt_q[j] != '1)) begin
          cnt_q[j] <= cnt_q[j] + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/qerror_histogram_counter.sv =====
// Q-error histogram counter.
// Words enter through a queue-like port: a word is taken at a clock edge with
// push_i high and full_o low. func_i selects recording a cardinality pair,
// reading one counter at counter_addr_i, or clearing all counters.
// Results leave through a second queue-like port: the oldest result is shown
// while empty_o is low and is taken at an edge with pop_i high.
// Every word gives exactly one result, in order; a spare func_i gives zeros.
// A word is held in the classify register, passes a two-entry queue, and is
// applied to the counters as it is written into a two-entry result queue.
// One word per cycle is sustained while the receiver pops every cycle;
// the counter bank updates at most once per cycle.
// When the receiver stops popping, the result queue fills, then the middle
// queue, and full_o rises; nothing is dropped.
// Reset clears every counter and configuration register at once.
// Configuration writes through cfg_we_i take effect at the next edge and are
// meant to be made while no word is in flight.
module qerror_histogram_counter import qhc_pkg::*; #(
  parameter int unsigned NumThresholds = DefNumThresholds,
  parameter int unsigned ProfileSlots  = DefProfileSlots,
  parameter int unsigned CountWidth    = DefCountWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] true_card_i,
  input  logic [31:0] est_card_i,
  input  logic [6:0]  counter_addr_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] read_data_o,
  output logic [3:0]  profile_bin_o,
  output logic [1:0]  sel_class_o,
  output logic        q_above_two_o
);

  logic    fr_valid, mid_full, mid_empty, mid_pop, res_push, res_full;
  entry_t  fr_ent, mid_ent;
  result_t res_in, res_out;

  qhc_front #(
    .NumThresholds(NumThresholds),
    .ProfileSlots (ProfileSlots)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push_i),
    .full_o        (full_o),
    .func_i        (func_i),
    .true_card_i   (true_card_i),
    .est_card_i    (est_card_i),
    .counter_addr_i(counter_addr_i),
    .ent_valid_o   (fr_valid),
    .ent_o         (fr_ent),
    .ent_full_i    (mid_full)
  );

  qhc_fifo #(
    .T    (entry_t),
    .Depth(QueueDepth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_valid),
    .wdata_i(fr_ent),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .rdata_o(mid_ent),
    .empty_o(mid_empty)
  );

  qhc_back #(
    .NumThresholds(NumThresholds),
    .ProfileSlots (ProfileSlots),
    .CountWidth   (CountWidth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ent_empty_i(mid_empty),
    .ent_i      (mid_ent),
    .ent_pop_o  (mid_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  qhc_fifo #(
    .T    (result_t),
    .Depth(QueueDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_out),
    .empty_o(empty_o)
  );

  assign read_data_o   = res_out.read_data;
  assign profile_bin_o = res_out.bin;
  assign sel_class_o   = res_out.cls;
  assign q_above_two_o = res_out.bad;

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && profile_bin_o != 4'd0) |-> q_above_two_o)
    else $error("nonzero bin without q-error above two");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && read_data_o != 32'd0) |->
    (profile_bin_o == 4'd0 && sel_class_o == 2'd0 && !q_above_two_o))
    else $error("read result carries record fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> mid_full)
    else $error("input stalled while middle queue has room");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import qhc_pkg::*;

  localparam int NThr = 6;
  localparam int Slots = 12;
  localparam int ProfN = NThr * Slots;
  localparam int BadBase = ProfN;
  localparam int AllBase = BadBase + NThr * 4;
  localparam int FixBase = AllBase + 4;
  localparam int MapEnd = FixBase + 4;
  localparam logic [1:0] FuncSpare = 2'd3;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  bin;
    logic [1:0]  cls;
    logic        bad;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [1:0]  func_i = FuncRecord;
  logic [31:0] true_card_i = '0;
  logic [31:0] est_card_i = '0;
  logic [6:0]  counter_addr_i = '0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [31:0] read_data_o;
  logic [3:0]  profile_bin_o;
  logic [1:0]  sel_class_o;
  logic        q_above_two_o;

  qerror_histogram_counter uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [31:0] row_total_m;
  logic [2:0]  active_m;
  logic [31:0] thr_m [NThr];
  logic [31:0] counters_m [MapEnd];
  outcome_t    pending_q [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
    errors++;
  endtask

  function automatic void bump_counter(input int idx);
    if (counters_m[idx] != 32'hFFFF_FFFF) counters_m[idx]++;
  endfunction

  function automatic outcome_t score_word(input logic [1:0] fn, input logic [31:0] tc,
                                          input logic [31:0] ec, input logic [6:0] addr);
    outcome_t o;
    logic [63:0] a, b, hi, lo, t;
    int nact;
    o = '0;
    if (fn == FuncRead) begin
      o.read_data = (addr < MapEnd) ? counters_m[addr] : 32'd0;
      return o;
    end
    if (fn == FuncClear) begin
      foreach (counters_m[i]) counters_m[i] = '0;
      return o;
    end
    if (fn != FuncRecord) return o;
    a = (tc == 0) ? 64'd1 : 64'(tc);
    b = (ec == 0) ? 64'd1 : 64'(ec);
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    o.bad = hi > 2 * lo;
    o.bin = 0;
    if (o.bad) begin
      o.bin = 4'(Slots - 3);
      for (int i = 1; i < Slots - 3; i++)
        if (hi <= (i + 2) * lo) begin
          o.bin = 4'(i);
          break;
        end
    end
    t = (row_total_m == 0) ? 64'd1 : 64'(row_total_m);
    if (tc < 2) o.cls = 0;
    else if (200 * 64'(tc) <= t) o.cls = 1;
    else if (50 * 64'(tc) <= t) o.cls = 2;
    else o.cls = 3;
    bump_counter(AllBase + o.cls);
    nact = (active_m > NThr) ? NThr : active_m;
    for (int i = 0; i < nact; i++) begin
      if (!(tc > thr_m[i] || ec > thr_m[i])) continue;
      if (o.bad) begin
        bump_counter(BadBase + i * 4 + o.cls);
        bump_counter(i * Slots + ((tc > ec) ? Slots - 2 : Slots - 1));
      end
      bump_counter(i * Slots + o.bin);
    end
    for (int i = 0; i < 4; i++)
      if (tc > FixedLimit[i] && o.bad) bump_counter(FixBase + i);
    return o;
  endfunction

  task automatic send_word(input logic [1:0] fn, input logic [31:0] tc,
                           input logic [31:0] ec, input logic [6:0] addr);
    outcome_t exp_o;
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i <= 1'b1;
    func_i <= fn;
    true_card_i <= tc;
    est_card_i <= ec;
    counter_addr_i <= addr;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    exp_o = score_word(fn, tc, ec, addr);
    pending_q.insert(pending_q.size(), exp_o);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) pop_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected word", read_data_o, 32'd0);
      end else begin
        outcome_t e;
        e = pending_q.pop_front();
        if (read_data_o !== e.read_data)
          report_mismatch("read_data", read_data_o, e.read_data);
        if (profile_bin_o !== e.bin)
          report_mismatch("profile_bin", 32'(profile_bin_o), 32'(e.bin));
        if (sel_class_o !== e.cls)
          report_mismatch("sel_class", 32'(sel_class_o), 32'(e.cls));
        if (q_above_two_o !== e.bad)
          report_mismatch("q_above_two", 32'(q_above_two_o), 32'(e.bad));
      end
    end
  end

  task automatic drain;
    push_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      RegRowTotal: row_total_m = val;
      RegActiveThr: active_m = val[2:0];
      default: thr_m[idx - RegThresholdA] = val;
    endcase
  endtask

  task automatic set_thresholds(input logic [2:0] n, input logic [31:0] rt,
                                input logic [31:0] t0, input logic [31:0] step);
    drain();
    write_reg(RegRowTotal, rt);
    write_reg(RegActiveThr, 32'(n));
    for (int i = 0; i < NThr; i++) write_reg(3'(RegThresholdA + i), t0 + step * i);
  endtask

  task automatic dump_all;
    for (int a = 0; a <= MapEnd; a++) send_word(FuncRead, $urandom, $urandom, 7'(a));
  endtask

  function automatic logic [31:0] pick_card();
    case ($urandom_range(5))
      0: return $urandom_range(3);
      1: return $urandom_range(20000);
      2: return $urandom;
      3: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(2000);
    endcase
  endfunction

  task automatic test_directed;
    set_thresholds(3'd7, 32'd0, 32'd0, 32'd100);
    send_word(FuncRecord, 0, 0, 0);
    send_word(FuncRecord, 1, 0, 0);
    send_word(FuncRecord, 0, 3, 0);
    send_word(FuncRecord, 32'hFFFF_FFFF, 0, 0);
    send_word(FuncRecord, 0, 32'hFFFF_FFFF, 7'h7F);
    send_word(FuncRecord, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    for (int k = 2; k <= 12; k++) send_word(FuncRecord, 100 * k, 100, 0);
    send_word(FuncRecord, 201, 100, 0);
    send_word(FuncRecord, 10001, 5000, 0);
    send_word(FuncSpare, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
    send_word(FuncRead, 0, 0, 7'd127);
    send_word(FuncRead, 0, 0, 7'(FixBase));
    dump_all();
    send_word(FuncClear, 0, 0, 0);
    send_word(FuncRead, 0, 0, 7'(AllBase));
  endtask

  task automatic test_selectivity;
    set_thresholds(3'd3, 32'd10000, 32'd5, 32'd1000);
    for (int tc = 48; tc <= 202; tc += 1)
      if (tc < 52 || tc > 198) send_word(FuncRecord, tc, tc * 3, 0);
    send_word(FuncRecord, 2, 1, 0);
    dump_all();
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      int r;
      logic [31:0] tc, ec;
      r = $urandom_range(99);
      tc = pick_card();
      ec = ($urandom_range(1)) ? pick_card() : tc * $urandom_range(1, 12) + $urandom_range(3);
      if (r < 75) send_word(FuncRecord, tc, ec, 7'($urandom));
      else if (r < 95) send_word(FuncRead, tc, ec, 7'($urandom));
      else if (r < 98) send_word(FuncSpare, tc, ec, 7'($urandom));
      else send_word(FuncClear, tc, ec, 7'($urandom));
    end
  endtask

  initial begin
    row_total_m = '0;
    active_m = '0;
    foreach (thr_m[i]) thr_m[i] = '0;
    foreach (counters_m[i]) counters_m[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 22;
    recv_idle_pct = 61;
    test_directed();
    test_selectivity();
    set_thresholds(3'd6, 32'hFFFF_FFFF, 32'd0, 32'd3000);
    test_random(80);
    dump_all();
    send_idle_pct = 61;
    recv_idle_pct = 22;
    set_thresholds(3'd2, 32'd400, 32'hFFFF_FFFF, 32'd0);
    test_random(80);
    dump_all();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_thresholds(3'd0, 32'd1, 32'd10, 32'd7);
    test_random(20);
    set_thresholds(3'd5, 32'd123456, 32'd1, 32'd900);
    test_random(50);
    dump_all();
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qhc_pkg.sv
hdl/qhc_fifo.sv
hdl/qhc_front.sv
hdl/qhc_back.sv
hdl/qerror_histogram_counter.sv
bench/tb_top.sv
